/* hw/rtl/hlg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_pkg
// Shared widths, register indexes and the stage record of the hexagonal
// lattice gas propagation block.
// ----------------------------------------------------------------------------
package hlg_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MIN_DIM      = 2;
   localparam int CELL_W       = 8;
   localparam int ROW_W        = 16;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int GRID_WIDTH_W = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int NUM_BANKS    = 3;
   localparam int BANK_W       = $clog2(NUM_BANKS);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);

   localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET  = GRID_WIDTH_W'(1024);
   localparam logic [ROW_W-1:0]        GRID_HEIGHT_RESET = ROW_W'(1024);

   // one accepted cell plus the bank bytes of the two rows above it
   typedef struct packed {
      logic              vld;
      logic [CELL_W-1:0] in_cell;
      logic [CELL_W-1:0] up_cell;
      logic [CELL_W-1:0] mid_cell;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              r_ge1;
      logic              r_ge2;
      logic              c_ge1;
      logic              c_ge2;
      logic              last_row;
      logic              last_col;
   } stg_type;

endpackage
`default_nettype wire

/* hw/rtl/hlg_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_req_if
// Input cell channel: valid/ready handshake with one cell byte.
// ----------------------------------------------------------------------------
interface hlg_req_if import hlg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_in;

   modport source (output valid, output cell_in, input ready);
   modport sink   (input valid, input cell_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hlg_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_rsp_if
// Result channel: valid/ready handshake with a propagated cell and its place.
// ----------------------------------------------------------------------------
interface hlg_rsp_if import hlg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_out;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic              last_of_run;
   logic              frame_done;

   modport source (output valid, output cell_out, output out_row, output out_col,
                   output last_of_run, output frame_done, input ready);
   modport sink   (input valid, input cell_out, input out_row, input out_col,
                   input last_of_run, input frame_done, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hlg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hlg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/hlg_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_front
// Configuration registers, raster counters, three rotating row banks and the
// input stage register.
// ----------------------------------------------------------------------------
module hlg_front import hlg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   hlg_req_if.sink               req_port,
   input  logic                  stg_take,
   output stg_type               stg
);

   logic [GRID_WIDTH_W-1:0] grid_width_ff, grid_width_in;
   logic [ROW_W-1:0]        grid_height_ff, grid_height_in;
   logic [GRID_WIDTH_W-1:0] w_eff;
   logic [ROW_W-1:0]        h_eff;
   logic [COL_W-1:0]        w_last;
   logic [ROW_W-1:0]        h_last;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [BANK_W-1:0] bank_ff, bank_in;

   logic              stg_vld_ff, stg_vld_in;
   logic [CELL_W-1:0] stg_cell_ff;
   logic [ROW_W-1:0]  stg_row_ff;
   logic [COL_W-1:0]  stg_col_ff;
   logic [BANK_W-1:0] stg_bank_ff;
   logic              stg_r_ge1_ff, stg_r_ge2_ff, stg_c_ge1_ff, stg_c_ge2_ff;
   logic              stg_last_row_ff, stg_last_col_ff;

   logic              accept;
   logic              restart;
   logic [BANK_W-1:0] mid_sel, up_sel;
   logic [CELL_W-1:0] bank_rd [NUM_BANKS];

   // effective grid size
   always_comb begin
      if (grid_width_ff < GRID_WIDTH_W'(MIN_DIM)) begin
         w_eff = GRID_WIDTH_W'(MIN_DIM);
      end else if (grid_width_ff > GRID_WIDTH_W'(MAX_WIDTH)) begin
         w_eff = GRID_WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff < ROW_W'(MIN_DIM)) begin
         h_eff = ROW_W'(MIN_DIM);
      end else begin
         h_eff = grid_height_ff;
      end
   end

   assign w_last = COL_W'(w_eff - GRID_WIDTH_W'(1));
   assign h_last = h_eff - ROW_W'(1);

   assign req_port.ready = !stg_vld_ff || stg_take;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      restart        = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               grid_width_in = csr_wr_data[GRID_WIDTH_W-1:0];
               restart       = 1'b1;
            end
            CSR_GRID_HEIGHT: begin
               grid_height_in = csr_wr_data[ROW_W-1:0];
               restart        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // raster position and bank rotation; the written bank becomes the middle row
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in  = '0;
            bank_in = (bank_ff == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_ff + BANK_W'(1);
            row_in  = (row_ff == h_last) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      stg_vld_in = stg_vld_ff;
      if (accept) begin
         stg_vld_in = 1'b1;
      end else if (stg_take) begin
         stg_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         row_ff         <= '0;
         col_ff         <= '0;
         bank_ff        <= '0;
         stg_vld_ff     <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         bank_ff        <= bank_in;
         stg_vld_ff     <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_cell_ff     <= req_port.cell_in;
         stg_row_ff      <= row_ff;
         stg_col_ff      <= col_ff;
         stg_bank_ff     <= bank_ff;
         stg_r_ge1_ff    <= row_ff != '0;
         stg_r_ge2_ff    <= row_ff > ROW_W'(1);
         stg_c_ge1_ff    <= col_ff != '0;
         stg_c_ge2_ff    <= col_ff > COL_W'(1);
         stg_last_row_ff <= row_ff == h_last;
         stg_last_col_ff <= col_ff == w_last;
      end
   end

   for (genvar i = 0; i < NUM_BANKS; i++) begin : g_bank
      hlg_ram #(
         .WIDTH (CELL_W),
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && (bank_ff == BANK_W'(i))),
         .wr_addr (col_ff),
         .wr_data (req_port.cell_in),
         .rd_en   (accept),
         .rd_addr (col_ff),
         .rd_data (bank_rd[i])
      );
   end

   // row r-1 sits one bank behind the written one, row r-2 two behind
   assign mid_sel = (stg_bank_ff == '0) ? BANK_W'(NUM_BANKS - 1) : stg_bank_ff - BANK_W'(1);
   assign up_sel  = (stg_bank_ff == BANK_W'(NUM_BANKS - 1)) ? '0 : stg_bank_ff + BANK_W'(1);

   always_comb begin
      stg.vld      = stg_vld_ff;
      stg.in_cell  = stg_cell_ff;
      stg.up_cell  = bank_rd[up_sel];
      stg.mid_cell = bank_rd[mid_sel];
      stg.row      = stg_row_ff;
      stg.col      = stg_col_ff;
      stg.r_ge1    = stg_r_ge1_ff;
      stg.r_ge2    = stg_r_ge2_ff;
      stg.c_ge1    = stg_c_ge1_ff;
      stg.c_ge2    = stg_c_ge2_ff;
      stg.last_row = stg_last_row_ff;
      stg.last_col = stg_last_col_ff;
   end

`ifndef SYNTHESIS
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("column counter beyond row width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last)
      else $error("row counter beyond frame height");
`endif

endmodule
`default_nettype wire

/* hw/rtl/hlg_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_back
// 3x3 neighborhood windows, direction gather and the result register that
// hands out up to four cells per transaction.
// ----------------------------------------------------------------------------
module hlg_back import hlg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stg_type   stg,
   output logic      stg_take,
   hlg_rsp_if.source rsp_port
);

   localparam int NUM_RES = 4;
   localparam int RES_W   = $clog2(NUM_RES);

   // result slots in emission order
   localparam logic [RES_W-1:0] RES_UP_LEFT   = RES_W'(0); // (r-1, c-1)
   localparam logic [RES_W-1:0] RES_LAST_LEFT = RES_W'(1); // (r,   c-1)
   localparam logic [RES_W-1:0] RES_UP_EDGE   = RES_W'(2); // (r-1, c)
   localparam logic [RES_W-1:0] RES_LAST_EDGE = RES_W'(3); // (r,   c)

   // columns c-2, c-1, c and a zero pad above
   typedef logic [3:0][CELL_W-1:0] win_type;

   function automatic logic [CELL_W-1:0] gather(
      input logic       odd,
      input logic       up,
      input logic       dn,
      input logic       lf,
      input logic       rt,
      input logic [1:0] ox,
      input win_type    prv,
      input win_type    cur,
      input win_type    nxt
   );
      logic [1:0]        ia;
      logic [1:0]        ib;
      logic [CELL_W-1:0] v;
      ia      = ox + {1'b0, odd} - 2'd1;
      ib      = ox + {1'b0, odd};
      v       = '0;
      v[0]    = dn & lf & nxt[ia][0];
      v[1]    = lf & cur[ox - 2'd1][1];
      v[2]    = up & lf & prv[ia][2];
      v[3]    = up & rt & prv[ib][3];
      v[4]    = rt & cur[ox + 2'd1][4];
      v[5]    = dn & rt & nxt[ib][5];
      v[7:6]  = cur[ox][7:6];
      return v;
   endfunction

   logic [1:0][CELL_W-1:0] up_win_ff, mid_win_ff, cur_win_ff;
   win_type                up_win, mid_win, cur_win;

   logic [NUM_RES-1:0]              vld_ff, vld_in;
   logic [NUM_RES-1:0][CELL_W-1:0]  res_cell_ff;
   logic [ROW_W-1:0]                res_row_ff;
   logic [COL_W-1:0]                res_col_ff;

   logic [NUM_RES-1:0]             new_vld;
   logic [NUM_RES-1:0][CELL_W-1:0] new_cell;
   logic [RES_W-1:0]               sel;
   logic [NUM_RES-1:0]             sel_oh;
   logic                           last;
   logic                           rsp_take;

   assign up_win  = {CELL_W'(0), stg.up_cell,  up_win_ff[1],  up_win_ff[0]};
   assign mid_win = {CELL_W'(0), stg.mid_cell, mid_win_ff[1], mid_win_ff[0]};
   assign cur_win = {CELL_W'(0), stg.in_cell,  cur_win_ff[1], cur_win_ff[0]};

   // row r-1 has parity opposite to row r
   always_comb begin
      new_cell[RES_UP_LEFT]   = gather(~stg.row[0], stg.r_ge2, 1'b1, stg.c_ge2, 1'b1, 2'd1,
                                       up_win, mid_win, cur_win);
      new_cell[RES_LAST_LEFT] = gather(stg.row[0], 1'b1, 1'b0, stg.c_ge2, 1'b1, 2'd1,
                                       mid_win, cur_win, cur_win);
      new_cell[RES_UP_EDGE]   = gather(~stg.row[0], stg.r_ge2, 1'b1, 1'b1, 1'b0, 2'd2,
                                       up_win, mid_win, cur_win);
      new_cell[RES_LAST_EDGE] = gather(stg.row[0], 1'b1, 1'b0, 1'b1, 1'b0, 2'd2,
                                       mid_win, cur_win, cur_win);
      new_vld[RES_UP_LEFT]    = stg.r_ge1 & stg.c_ge1;
      new_vld[RES_LAST_LEFT]  = stg.last_row & stg.c_ge1;
      new_vld[RES_UP_EDGE]    = stg.last_col & stg.r_ge1;
      new_vld[RES_LAST_EDGE]  = stg.last_col & stg.last_row;
   end

   always_comb begin
      if (vld_ff[RES_UP_LEFT]) begin
         sel = RES_UP_LEFT;
      end else if (vld_ff[RES_LAST_LEFT]) begin
         sel = RES_LAST_LEFT;
      end else if (vld_ff[RES_UP_EDGE]) begin
         sel = RES_UP_EDGE;
      end else begin
         sel = RES_LAST_EDGE;
      end
   end

   assign sel_oh   = NUM_RES'(1) << sel;
   assign last     = (vld_ff & ~sel_oh) == '0;
   assign rsp_take = rsp_port.valid && rsp_port.ready;
   assign stg_take = stg.vld && ((vld_ff == '0) || (rsp_take && last));

   assign rsp_port.valid       = vld_ff != '0;
   assign rsp_port.cell_out    = res_cell_ff[sel];
   assign rsp_port.out_row     = sel[0] ? res_row_ff : res_row_ff - ROW_W'(1);
   assign rsp_port.out_col     = sel[1] ? res_col_ff : res_col_ff - COL_W'(1);
   assign rsp_port.last_of_run = last;
   assign rsp_port.frame_done  = sel == RES_LAST_EDGE;

   always_comb begin
      vld_in = vld_ff;
      if (rsp_take) begin
         vld_in = vld_ff & ~sel_oh;
      end
      if (stg_take) begin
         vld_in = new_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_take) begin
         up_win_ff   <= {stg.up_cell,  up_win_ff[1]};
         mid_win_ff  <= {stg.mid_cell, mid_win_ff[1]};
         cur_win_ff  <= {stg.in_cell,  cur_win_ff[1]};
         res_cell_ff <= new_cell;
         res_row_ff  <= stg.row;
         res_col_ff  <= stg.col;
      end
   end

`ifndef SYNTHESIS
   a_edge_needs_left: assert property (@(posedge clock) disable iff (reset)
      stg_take && new_vld[RES_LAST_EDGE] |-> new_vld[RES_LAST_LEFT])
      else $error("last-row edge cell loaded without its left neighbor result");

   a_up_edge_needs_left: assert property (@(posedge clock) disable iff (reset)
      stg_take && new_vld[RES_UP_EDGE] |-> new_vld[RES_UP_LEFT])
      else $error("upper edge cell loaded without its left neighbor result");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_port.last_of_run |=> rsp_port.valid)
      else $error("run ended before its last result");

   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.frame_done |-> rsp_port.last_of_run)
      else $error("frame end cell not the last of its run");
`endif

endmodule
`default_nettype wire

/* hw/rtl/hex_lattice_gas_propagation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_lattice_gas_propagation
// Streaming propagation step of a hexagonal lattice gas: raster-order cell
// bytes in, propagated cells out once their lower neighbors have arrived.
//
//   channel   dir   handshake      payload
//   req_port  in    valid/ready    cell_in
//   rsp_port  out   valid/ready    cell_out, out_row, out_col,
//                                  last_of_run, frame_done
//   csr_*     in    csr_wr_en      csr_index, csr_wr_data
//
// If the output is ready, one transaction per cycle while each yields one result;
// at row ends past row 0 and in the last row past column 0 a transaction yields
// two to four results, sent one per cycle from the result register, so the input
// is held. A result passes the input stage and row bank read registers, then the
// result register. Reset clears counters, bank rotation and valid state; row banks
// are not cleared. A stalled output holds one transaction in the input stage.
// ----------------------------------------------------------------------------
module hex_lattice_gas_propagation import hlg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   hlg_req_if.sink               req_port,
   hlg_rsp_if.source             rsp_port
);

   stg_type stg;
   logic    stg_take;

   hlg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_port),
      .stg_take    (stg_take),
      .stg         (stg)
   );

   hlg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .stg      (stg),
      .stg_take (stg_take),
      .rsp_port (rsp_port)
   );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for hex_lattice_gas_propagation: streams raster-order cell
// bytes through the request channel, predicts every propagated cell from a
// local copy of the three row stores and checks each result transaction in
// order, under several grid sizes and sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import hlg_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 25;

   // row store selectors for the neighbor gather
   localparam int ROW_PREV2 = 0;
   localparam int ROW_PREV1 = 1;
   localparam int ROW_THIS  = 2;

   typedef struct packed {
      logic [CELL_W-1:0] cell_byte;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              last_of_run;
      logic              frame_done;
   } cell_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   hlg_req_if req_if ();
   hlg_rsp_if rsp_if ();

   hex_lattice_gas_propagation uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_if),
      .rsp_port    (rsp_if)
   );

   // local copy of the block state
   logic [CELL_W-1:0]       prev2_row [MAX_WIDTH];
   logic [CELL_W-1:0]       prev1_row [MAX_WIDTH];
   logic [CELL_W-1:0]       this_row  [MAX_WIDTH];
   logic [GRID_WIDTH_W-1:0] width_setting;
   logic [ROW_W-1:0]        height_setting;
   int                      scan_row;
   int                      scan_col;

   cell_result_type pending_cells [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct;
   int              recv_idle_pct;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hex_lattice_gas_propagation regression: fail");
         $finish;
      end
   end

   function automatic int grid_w();
      int w;
      w = width_setting;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int grid_h();
      return (height_setting < MIN_DIM) ? MIN_DIM : int'(height_setting);
   endfunction

   function automatic logic [CELL_W-1:0] stored_cell(input int sel, input int idx);
      if (idx < 0 || idx >= MAX_WIDTH) return '0;
      case (sel)
         ROW_PREV2: return prev2_row[idx];
         ROW_PREV1: return prev1_row[idx];
         default:   return this_row[idx];
      endcase
   endfunction

   function automatic logic dir_bit(input int sel, input int idx, input int k);
      logic [CELL_W-1:0] b;
      b = stored_cell(sel, idx);
      return b[k];
   endfunction

   function automatic cell_result_type gather_result(input int y, input int x, input int h,
                                                     input int w, input int prev_sel,
                                                     input int cur_sel, input int next_sel);
      cell_result_type res;
      logic [CELL_W-1:0] v;
      int m;
      m = y % 2;
      v = stored_cell(cur_sel, x) & 8'hC0;
      v[0] = (y < h - 1 && x > 0)     && dir_bit(next_sel, x + m - 1, 0);
      v[1] = (x > 0)                  && dir_bit(cur_sel, x - 1, 1);
      v[2] = (y > 0 && x > 0)         && dir_bit(prev_sel, x + m - 1, 2);
      v[3] = (y > 0 && x < w - 1)     && dir_bit(prev_sel, x + m, 3);
      v[4] = (x < w - 1)              && dir_bit(cur_sel, x + 1, 4);
      v[5] = (y < h - 1 && x < w - 1) && dir_bit(next_sel, x + m, 5);
      res.cell_byte   = v;
      res.row         = y[ROW_W-1:0];
      res.col         = x[COL_W-1:0];
      res.last_of_run = 1'b0;
      res.frame_done  = (y == h - 1 && x == w - 1);
      return res;
   endfunction

   // queue the cells released by one accepted input cell
   task automatic propagate_cell(input logic [CELL_W-1:0] value);
      cell_result_type found [4];
      int n;
      int w;
      int h;
      int r;
      int c;
      int i;
      w = grid_w();
      h = grid_h();
      n = 0;
      if (scan_row >= h || scan_col >= w) begin
         scan_row = 0;
         scan_col = 0;
      end
      r = scan_row;
      c = scan_col;
      this_row[c] = value;
      if (r >= 1 && c >= 1) begin
         found[n] = gather_result(r - 1, c - 1, h, w, ROW_PREV2, ROW_PREV1, ROW_THIS);
         n++;
      end
      // last row has no lower neighbors, flush it as it comes
      if (r == h - 1 && c >= 1) begin
         found[n] = gather_result(r, c - 1, h, w, ROW_PREV1, ROW_THIS, ROW_THIS);
         n++;
      end
      if (c == w - 1) begin
         if (r >= 1) begin
            found[n] = gather_result(r - 1, c, h, w, ROW_PREV2, ROW_PREV1, ROW_THIS);
            n++;
         end
         if (r == h - 1) begin
            found[n] = gather_result(r, c, h, w, ROW_PREV1, ROW_THIS, ROW_THIS);
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         if (i == n - 1) found[i].last_of_run = 1'b1;
         pending_cells.push_back(found[i]);
      end
      c++;
      if (c >= w) begin
         c = 0;
         for (i = 0; i < MAX_WIDTH; i++) begin
            prev2_row[i] = prev1_row[i];
            prev1_row[i] = this_row[i];
         end
         r++;
         if (r >= h) r = 0;
      end
      scan_row = r;
      scan_col = c;
   endtask

   task automatic compare_field(input string name, input logic [ROW_W-1:0] want,
                                input logic [ROW_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      cell_result_type want;
      if (pending_cells.size() == 0) begin
         error_count++;
         $display("%0t: unexpected transaction expected none actual cell %0h at (%0d,%0d)",
                  $time, rsp_if.cell_out, rsp_if.out_row, rsp_if.out_col);
      end else begin
         want = pending_cells.pop_front();
         compare_field("cell_out", ROW_W'(want.cell_byte), ROW_W'(rsp_if.cell_out));
         compare_field("out_row", want.row, rsp_if.out_row);
         compare_field("out_col", ROW_W'(want.col), ROW_W'(rsp_if.out_col));
         compare_field("last_of_run", ROW_W'(want.last_of_run), ROW_W'(rsp_if.last_of_run));
         compare_field("frame_done", ROW_W'(want.frame_done), ROW_W'(rsp_if.frame_done));
      end
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) check_result();
   end

   task automatic send_cell(input logic [CELL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cell_in <= value;
      do @(posedge clock); while (!req_if.ready);
      propagate_cell(value);
   endtask

   // let the block go quiet before any register write
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_GRID_WIDTH) width_setting = data[GRID_WIDTH_W-1:0];
      else height_setting = data;
      // any write restarts the frame
      scan_row = 0;
      scan_col = 0;
      @(posedge clock);
   endtask

   function automatic logic [CELL_W-1:0] random_cell();
      case ($urandom_range(3))
         0:       return CELL_W'(1 << $urandom_range(7));
         1:       return ~CELL_W'(1 << $urandom_range(7));
         default: return CELL_W'($urandom_range(255));
      endcase
   endfunction

   task automatic test_min_grid();
      write_csr(CSR_GRID_WIDTH, 2);
      write_csr(CSR_GRID_HEIGHT, 2);
      send_cell(8'hFF);
      send_cell(8'h00);
      send_cell(8'h55);
      send_cell(8'hAA);
      wait_idle();
   endtask

   // sizes below two fall back to two; one-hot cells isolate each direction
   task automatic test_dims_below_min();
      int i;
      write_csr(CSR_GRID_WIDTH, 1);
      write_csr(CSR_GRID_HEIGHT, 0);
      for (i = 0; i < 4; i++) send_cell(CELL_W'(1 << i));
      wait_idle();
      write_csr(CSR_GRID_WIDTH, 0);
      write_csr(CSR_GRID_HEIGHT, 1);
      for (i = 4; i < 8; i++) send_cell(CELL_W'(1 << i));
      wait_idle();
   endtask

   // full 3x3 frame: the odd middle row shifts its diagonal neighbors
   task automatic test_odd_row_offsets();
      int i;
      write_csr(CSR_GRID_WIDTH, 3);
      write_csr(CSR_GRID_HEIGHT, 3);
      for (i = 0; i < 9; i++) send_cell((i == 4) ? 8'hFF : 8'h3F);
      wait_idle();
   endtask

   task automatic test_restart_mid_frame();
      int i;
      write_csr(CSR_GRID_WIDTH, 2);
      write_csr(CSR_GRID_HEIGHT, 16'hFFFF);
      for (i = 0; i < 5; i++) send_cell(random_cell());
      wait_idle();
      write_csr(CSR_GRID_HEIGHT, 2);
      for (i = 0; i < 4; i++) send_cell(random_cell());
      wait_idle();
   endtask

   task automatic test_random_frames(input int send_pct, input int recv_pct);
      int sent;
      int w_val;
      int h_val;
      int fw;
      int fh;
      int count;
      int k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         case ($urandom_range(9))
            0:       w_val = $urandom_range(1);
            1:       w_val = $urandom_range(9, 40);
            default: w_val = $urandom_range(2, 7);
         endcase
         case ($urandom_range(9))
            0:       h_val = $urandom_range(1);
            1:       h_val = 65535;
            default: h_val = $urandom_range(2, 5);
         endcase
         write_csr(CSR_GRID_HEIGHT, CSR_DATA_W'(h_val));
         write_csr(CSR_GRID_WIDTH, CSR_DATA_W'(w_val));
         fw = (w_val < MIN_DIM) ? MIN_DIM : w_val;
         fh = (h_val < MIN_DIM) ? MIN_DIM : h_val;
         // mostly whole frames, now and then cut short
         if (fh == 65535 || $urandom_range(3) == 0) count = $urandom_range(1, fw * 3);
         else count = fw * fh * $urandom_range(1, 2);
         if (count > PHASE_ITEMS - sent) count = PHASE_ITEMS - sent;
         for (k = 0; k < count; k++) send_cell(random_cell());
         wait_idle();
         sent += count;
      end
   endtask

   // width field saturated: clamps to the widest row, nothing released early
   task automatic test_widest_row();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_GRID_WIDTH, 16'hFFFF);
      write_csr(CSR_GRID_HEIGHT, 2);
      for (i = 0; i < 12; i++) send_cell(random_cell());
      wait_idle();
   endtask

   initial begin
      int i;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.cell_in = '0;
      width_setting  = GRID_WIDTH_RESET;
      height_setting = GRID_HEIGHT_RESET;
      scan_row       = 0;
      scan_col       = 0;
      send_idle_pct  = 36;
      recv_idle_pct  = 75;
      for (i = 0; i < MAX_WIDTH; i++) begin
         prev2_row[i] = '0;
         prev1_row[i] = '0;
         this_row[i]  = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_min_grid();
      test_dims_below_min();
      test_odd_row_offsets();
      test_restart_mid_frame();
      test_random_frames(36, 75);
      test_random_frames(75, 36);
      test_random_frames(0, 0);
      test_widest_row();

      if (error_count == 0) begin
         $display("hex_lattice_gas_propagation regression: pass");
      end else begin
         $display("hex_lattice_gas_propagation regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/hlg_pkg.sv
hw/rtl/hlg_req_if.sv
hw/rtl/hlg_rsp_if.sv
hw/rtl/hlg_ram.sv
hw/rtl/hlg_front.sv
hw/rtl/hlg_back.sv
hw/rtl/hex_lattice_gas_propagation.sv
dv/tb_top.sv
